>>> rtl/core/ring_buffer_deque_macros.svh
// Assertion macros shared by the ring buffer deque RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef RING_BUFFER_DEQUE_MACROS_SVH
`define RING_BUFFER_DEQUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RBD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/rbd_pkg.sv
// Shared types and constants of the ring buffer deque.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package rbd_pkg;

  localparam int unsigned ACTION_W   = 3;
  localparam int unsigned VALUE_W    = 32;
  localparam int unsigned INDEX_W    = 4;
  localparam int unsigned COUNT_W    = 5;
  localparam int unsigned CAP_W      = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned APB_ADDR_W = 3;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // Word index of the capacity register (paddr[2]).
  localparam logic REG_CAPACITY = 1'b0;

  typedef enum logic [ACTION_W-1:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_PUSH_FRONT = 3'd1,
    ACT_POP_BACK   = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_SWAP       = 3'd4
  } action_e;

endpackage

>>> rtl/core/rbd_req_if.sv
// Request channel of the ring buffer deque: valid/ready plus one action.
// Depends on rbd_pkg for the field widths.
`timescale 1ns / 1ps

interface rbd_req_if import rbd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [ACTION_W-1:0] action;
  logic [VALUE_W-1:0]  value;
  logic [INDEX_W-1:0]  index_a;
  logic [INDEX_W-1:0]  index_b;

  modport source (output valid, action, value, index_a, index_b, input ready);
  modport sink   (input valid, action, value, index_a, index_b, output ready);
endinterface

>>> rtl/core/rbd_rsp_if.sv
// Response channel of the ring buffer deque: valid/ready plus one result.
// Depends on rbd_pkg for the field widths.
`timescale 1ns / 1ps

interface rbd_rsp_if import rbd_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               applied;
  logic [COUNT_W-1:0] count;
  logic               empty_flag;
  logic               full_flag;
  logic [VALUE_W-1:0] front_value;
  logic [VALUE_W-1:0] back_value;

  modport source (output valid, applied, count, empty_flag, full_flag, front_value,
                  back_value, input ready);
  modport sink   (input valid, applied, count, empty_flag, full_flag, front_value,
                  back_value, output ready);
endinterface

>>> rtl/core/ring_buffer_deque.sv
// Double-ended ring buffer: the response is registered and appears in the cycle after the request is taken.
// Throughput is one request per cycle; the single output register is the only
// stage, and a request is taken whenever that register is empty or drained.
// Reset empties the buffer, clears the pointers and sets capacity to 16;
// slot contents are not reset. A capacity write also empties the buffer.
`timescale 1ns / 1ps
`include "ring_buffer_deque_macros.svh"

module ring_buffer_deque import rbd_pkg::*; #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned ELEM_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  rbd_req_if.sink               req_i,
  rbd_rsp_if.source             rsp_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OFS_W = ((PTR_W > INDEX_W) ? PTR_W : INDEX_W) + 1;

  logic [ELEM_WIDTH-1:0] slots_q [DEPTH];
  logic [ELEM_WIDTH-1:0] slots_d [DEPTH];
  logic [PTR_W-1:0]      head_q, head_d, tail_q, tail_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CAP_W-1:0]      cap_q;

  logic [CNT_W-1:0]      eff_cap;
  logic [PTR_W-1:0]      cap_max;
  logic [PTR_W-1:0]      head_inc, head_dec, tail_inc, tail_dec, back_idx;
  logic [OFS_W-1:0]      sum_a, sum_b;
  logic [PTR_W-1:0]      phys_a, phys_b;
  logic                  full, empty, swap_ok, applied_d;
  logic [ELEM_WIDTH-1:0] val_elem, front_d, back_d;
  action_e               act;
  logic                  req_fire, cfg_wr;

  logic                  rsp_valid_q, applied_q, empty_q, full_q;
  logic [COUNT_W-1:0]    count_q;
  logic [ELEM_WIDTH-1:0] front_q, back_q;

  // ---------------------------------------------------------------------------
  // Configuration port
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[APB_ADDR_W-1] == REG_CAPACITY);
  assign prdata = (paddr[APB_ADDR_W-1] == REG_CAPACITY) ? APB_DATA_W'(cap_q) : '0;

  // A capacity of zero acts as one; anything above DEPTH is clipped.
  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CNT_W'(1);
    end else if (32'(cap_q) > DEPTH) begin
      eff_cap = CNT_W'(DEPTH);
    end else begin
      eff_cap = CNT_W'(cap_q);
    end
  end
  assign cap_max = PTR_W'(eff_cap - CNT_W'(1));

  // ---------------------------------------------------------------------------
  // Pointer arithmetic, all modulo the effective capacity
  // ---------------------------------------------------------------------------
  assign head_inc = (CNT_W'(head_q) + CNT_W'(1) == eff_cap) ? '0 : head_q + PTR_W'(1);
  assign tail_inc = (CNT_W'(tail_q) + CNT_W'(1) == eff_cap) ? '0 : tail_q + PTR_W'(1);
  assign head_dec = (head_q == '0) ? cap_max : head_q - PTR_W'(1);
  assign tail_dec = (tail_q == '0) ? cap_max : tail_q - PTR_W'(1);

  // Offsets are checked against the count, so head plus offset stays below
  // twice the capacity and one conditional subtract wraps it.
  assign sum_a  = OFS_W'(head_q) + OFS_W'(req_i.index_a);
  assign sum_b  = OFS_W'(head_q) + OFS_W'(req_i.index_b);
  assign phys_a = PTR_W'((sum_a >= OFS_W'(eff_cap)) ? sum_a - OFS_W'(eff_cap) : sum_a);
  assign phys_b = PTR_W'((sum_b >= OFS_W'(eff_cap)) ? sum_b - OFS_W'(eff_cap) : sum_b);

  assign full    = cnt_q >= eff_cap;
  assign empty   = cnt_q == '0;
  assign swap_ok = (OFS_W'(req_i.index_a) < OFS_W'(cnt_q)) &&
                   (OFS_W'(req_i.index_b) < OFS_W'(cnt_q));

  assign act      = action_e'(req_i.action);
  assign val_elem = ELEM_WIDTH'(req_i.value);

  // ---------------------------------------------------------------------------
  // Next state for the request at the input
  // ---------------------------------------------------------------------------
  always_comb begin
    slots_d   = slots_q;
    head_d    = head_q;
    tail_d    = tail_q;
    cnt_d     = cnt_q;
    applied_d = 1'b0;
    case (act)
      ACT_PUSH_BACK: begin
        if (!full) begin
          slots_d[tail_q] = val_elem;
          tail_d          = tail_inc;
          cnt_d           = cnt_q + CNT_W'(1);
          applied_d       = 1'b1;
        end
      end
      ACT_PUSH_FRONT: begin
        if (!full) begin
          slots_d[head_dec] = val_elem;
          head_d            = head_dec;
          cnt_d             = cnt_q + CNT_W'(1);
          applied_d         = 1'b1;
        end
      end
      ACT_POP_BACK: begin
        if (!empty) begin
          tail_d    = tail_dec;
          cnt_d     = cnt_q - CNT_W'(1);
          applied_d = 1'b1;
        end
      end
      ACT_POP_FRONT: begin
        if (!empty) begin
          head_d    = head_inc;
          cnt_d     = cnt_q - CNT_W'(1);
          applied_d = 1'b1;
        end
      end
      ACT_SWAP: begin
        if (swap_ok) begin
          slots_d[phys_a] = slots_q[phys_b];
          slots_d[phys_b] = slots_q[phys_a];
          applied_d       = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Front and back are read after the action has taken effect.
  assign back_idx = (tail_d == '0) ? cap_max : tail_d - PTR_W'(1);
  assign front_d  = (cnt_d != '0) ? slots_d[head_d]   : '0;
  assign back_d   = (cnt_d != '0) ? slots_d[back_idx] : '0;

  // ---------------------------------------------------------------------------
  // Handshake and registers
  // ---------------------------------------------------------------------------
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign req_fire    = req_i.valid && req_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q       <= CAP_RESET;
      head_q      <= '0;
      tail_q      <= '0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cfg_wr) begin
        cap_q  <= pwdata[CAP_W-1:0];
        head_q <= '0;
        tail_q <= '0;
        cnt_q  <= '0;
      end else if (req_fire) begin
        head_q <= head_d;
        tail_q <= tail_d;
        cnt_q  <= cnt_d;
      end
      if (req_fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      slots_q   <= slots_d;
      applied_q <= applied_d;
      count_q   <= COUNT_W'(cnt_d);
      empty_q   <= cnt_d == '0;
      full_q    <= cnt_d == eff_cap;
      front_q   <= front_d;
      back_q    <= back_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.applied     = applied_q;
  assign rsp_o.count       = count_q;
  assign rsp_o.empty_flag  = empty_q;
  assign rsp_o.full_flag   = full_q;
  assign rsp_o.front_value = VALUE_W'(front_q);
  assign rsp_o.back_value  = VALUE_W'(back_q);

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `RBD_ASSERT_IMPL(a_cnt_in_cap, 1'b1, cnt_q <= eff_cap, "count exceeds capacity")
  `RBD_ASSERT_IMPL(a_ptr_in_cap, 1'b1, (CNT_W'(head_q) < eff_cap) && (CNT_W'(tail_q) < eff_cap),
                   "pointer beyond capacity")
  `RBD_ASSERT_IMPL(a_tail_track, 1'b1,
                   (OFS_W'(tail_q) == OFS_W'(head_q) + OFS_W'(cnt_q)) ||
                   (OFS_W'(tail_q) + OFS_W'(eff_cap) == OFS_W'(head_q) + OFS_W'(cnt_q)),
                   "tail does not equal head plus count")
  `RBD_ASSERT_IMPL(a_empty_zero, rsp_valid_q && empty_q,
                   (count_q == '0) && (front_q == '0) && (back_q == '0),
                   "empty result carries data")
  `RBD_ASSERT_NEXT(a_cfg_clears, cfg_wr, cnt_q == '0 && head_q == '0 && tail_q == '0,
                   "capacity write did not empty the buffer")

endmodule
